// ----- hdl/gn3_pkg.sv -----
`default_nettype none
package gn3_pkg;

	localparam int CoordW = 24;
	localparam int OutW   = 17;

	localparam logic [7:0] PERM [256] = '{
		8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,8'd194,
		8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,8'd37,8'd240,
		8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,
		8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,8'd57,8'd177,8'd33,8'd88,
		8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
		8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,8'd77,8'd146,8'd158,8'd231,
		8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
		8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,8'd65,8'd25,8'd63,8'd161,8'd1,
		8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,8'd200,
		8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,8'd164,8'd100,8'd109,8'd198,8'd173,
		8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,
		8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,
		8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,
		8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,
		8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,
		8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,
		8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,
		8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,
		8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,
		8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,
		8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
	};

	function automatic logic [7:0] perm(input logic [7:0] i);
		return PERM[i];
	endfunction

endpackage
`default_nettype wire

// ----- hdl/gn3_hash.sv -----
`default_nettype none
// Corner hashes: three dependent table lookups over three registered stages.
// Gives the low four bits of the hash of every corner, bit 0 = x, 1 = y, 2 = z.
module gn3_hash
	import gn3_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       en,
	input  wire logic [7:0] xi,
	input  wire logic [7:0] yi,
	input  wire logic [7:0] zi,
	output logic [3:0]      h [8]
);

	logic [7:0] zi_s1;
	logic [7:0] a_s1, b_s1;
	logic [7:0] aa_s2, ab_s2, ba_s2, bb_s2;
	logic [7:0] c_s3 [8];

	// Lookups A and B
	always_ff @(posedge clk) begin
		if (en) begin
			zi_s1 <= zi;
			a_s1  <= perm(xi) + yi;
			b_s1  <= perm(xi + 8'd1) + yi;
		end
	end

	// Lookups AA..BB
	always_ff @(posedge clk) begin
		if (en) begin
			aa_s2 <= perm(a_s1) + zi_s1;
			ab_s2 <= perm(a_s1 + 8'd1) + zi_s1;
			ba_s2 <= perm(b_s1) + zi_s1;
			bb_s2 <= perm(b_s1 + 8'd1) + zi_s1;
		end
	end

	// Final corner lookups
	always_ff @(posedge clk) begin
		if (en) begin
			c_s3[0] <= perm(aa_s2);
			c_s3[1] <= perm(ba_s2);
			c_s3[2] <= perm(ab_s2);
			c_s3[3] <= perm(bb_s2);
			c_s3[4] <= perm(aa_s2 + 8'd1);
			c_s3[5] <= perm(ba_s2 + 8'd1);
			c_s3[6] <= perm(ab_s2 + 8'd1);
			c_s3[7] <= perm(bb_s2 + 8'd1);
		end
	end

	always_comb begin
		for (int k = 0; k < 8; k++) h[k] = c_s3[k][3:0];
	end

endmodule
`default_nettype wire

// ----- hdl/gn3_fade.sv -----
`default_nettype none
// Quintic fade of one fraction over three registered stages.
module gn3_fade #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic [FRAC_BITS-1:0] f,
	output logic [FRAC_BITS:0]        fade
);

	localparam int FB = FRAC_BITS;
	localparam logic [FB+4:0] S10 = (FB+5)'(10) << FB;
	localparam logic [FB+4:0] S15 = (FB+5)'(15) << FB;
	localparam logic [FB:0]   ONE = (FB+1)'(1) << FB;

	logic [FB-1:0] f_s1, f2_s1, c_s2;
	logic [FB+4:0] g_s1, q_s2;
	logic [2*FB+4:0] r;

	// f*f and 15S-6f
	always_ff @(posedge clk) begin
		if (en) begin
			f_s1  <= f;
			f2_s1 <= FB'(({{FB{1'b0}}, f} * {{FB{1'b0}}, f}) >> FB);
			g_s1  <= S15 - ({3'b0, f, 2'b0} + {4'b0, f, 1'b0});
		end
	end

	// cube and q
	always_ff @(posedge clk) begin
		if (en) begin
			c_s2 <= FB'(({{FB{1'b0}}, f2_s1} * {{FB{1'b0}}, f_s1}) >> FB);
			q_s2 <= S10 - (FB+5)'(({{FB{1'b0}}, g_s1} * {{(FB+5){1'b0}}, f_s1}) >> FB);
		end
	end

	// c*q, clamped to one
	assign r = {{(FB+5){1'b0}}, c_s2} * {{FB{1'b0}}, q_s2};
	always_ff @(posedge clk) begin
		if (en) begin
			if ((r >> FB) > (2*FB+5)'(ONE)) fade <= ONE;
			else fade <= (FB+1)'(r >> FB);
		end
	end

endmodule
`default_nettype wire

// ----- hdl/gn3_lerp.sv -----
`default_nettype none
// a + floor(t*(b-a)/S), two registered stages.
module gn3_lerp #(
	parameter int FRAC_BITS = 16,
	parameter int VW        = 20
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic [FRAC_BITS:0]   t,
	input  wire logic signed [VW-1:0] a,
	input  wire logic signed [VW-1:0] b,
	output logic signed [VW-1:0]      y
);

	logic signed [VW:0]          d_s1;
	logic signed [VW-1:0]        a_s1, a_s2;
	logic signed [FRAC_BITS+1:0] t_s1;
	logic signed [VW+FRAC_BITS+1:0] p_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= (VW+1)'(b) - (VW+1)'(a);
			a_s1 <= a;
			t_s1 <= signed'({1'b0, t});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= (VW+FRAC_BITS+2)'(d_s1) * (VW+FRAC_BITS+2)'(t_s1);
			a_s2 <= a_s1;
		end
	end

	// arithmetic shift floors toward minus infinity
	assign y = a_s2 + VW'(p_s2 >>> FRAC_BITS);

endmodule
`default_nettype wire

// ----- hdl/gradient_noise_3d.sv -----
`default_nettype none
// Improved 3D gradient noise, one point per transfer.
// Input channel s_axis: tdata holds coord_x, coord_y, coord_z (unsigned fixed
// point, FRAC_BITS fraction bits, integer part used modulo 256).
// Output channel m_axis: tdata holds noise_value, unsigned Q1.16 in 0..65536.
// Throughput: one point per cycle while the receiver does not stall. The
// pipeline from input transfer to output valid: hash lookups and fade (three
// stages, overlapped), the corner gradient register, three lerp levels of two
// stages each with a register between levels, and the output register.
// The pipeline advances as a whole whenever its last stage is empty or the
// output is taken; a stalled receiver freezes every stage with nothing lost.
// s_axis_tready is high while the output stage is empty or being taken.
// Reset clears all valid bits; no item is in flight after reset.
module gradient_noise_3d
	import gn3_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [71:0] s_axis_tdata,  // coord_x, coord_y, coord_z
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata   // noise_value, zero fill
);

	localparam int FB  = FRAC_BITS;
	localparam int VW  = FB + 5;
	localparam int SW  = VW + 17;
	localparam int NST = 13;
	localparam logic signed [VW-1:0] SV = VW'(1) << FB;

	logic [NST-1:0] vld_q;
	logic en;
	assign en = !vld_q[NST-1] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[NST-1];

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[NST-2:0], s_axis_tvalid};
	end

	logic [CoordW-1:0] cx, cy, cz;
	assign cx = s_axis_tdata[23:0];
	assign cy = s_axis_tdata[47:24];
	assign cz = s_axis_tdata[71:48];

	logic [7:0] xi, yi, zi;
	assign xi = 8'((cx >> FB) & 24'd255);
	assign yi = 8'((cy >> FB) & 24'd255);
	assign zi = 8'((cz >> FB) & 24'd255);

	logic [3:0] h [8];
	gn3_hash u_hash (.clk, .en, .xi, .yi, .zi, .h);

	logic [FB:0] fu, fv, fw;
	gn3_fade #(.FRAC_BITS(FB)) u_fu (.clk, .en, .f(cx[FB-1:0]), .fade(fu));
	gn3_fade #(.FRAC_BITS(FB)) u_fv (.clk, .en, .f(cy[FB-1:0]), .fade(fv));
	gn3_fade #(.FRAC_BITS(FB)) u_fw (.clk, .en, .f(cz[FB-1:0]), .fade(fw));

	// delay fractions to hash output (3 stages)
	logic [FB-1:0] fx_s1, fy_s1, fz_s1, fx_s2, fy_s2, fz_s2, fx_s3, fy_s3, fz_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			fx_s1 <= cx[FB-1:0]; fy_s1 <= cy[FB-1:0]; fz_s1 <= cz[FB-1:0];
			fx_s2 <= fx_s1; fy_s2 <= fy_s1; fz_s2 <= fz_s1;
			fx_s3 <= fx_s2; fy_s3 <= fy_s2; fz_s3 <= fz_s2;
		end
	end

	// corner gradients at stage 4
	logic signed [VW-1:0] g_s4 [8];
	logic [FB:0] fv_s4, fw_s4, fw_s5, fw_s6;
	logic [FB:0] fv_s5;
	always_ff @(posedge clk) begin
		logic signed [VW-1:0] px, py, pz, gu, gv;
		logic [3:0] hh;
		if (en) begin
			for (int k = 0; k < 8; k++) begin
				hh = h[k];
				px = k[0] ? VW'(fx_s3) - SV : VW'(fx_s3);
				py = k[1] ? VW'(fy_s3) - SV : VW'(fy_s3);
				pz = k[2] ? VW'(fz_s3) - SV : VW'(fz_s3);
				gu = (hh < 4'd8) ? px : py;
				gv = (hh < 4'd4) ? py : ((hh == 4'd12 || hh == 4'd14) ? px : pz);
				g_s4[k] <= (hh[0] ? -gu : gu) + (hh[1] ? -gv : gv);
			end
			fv_s4 <= fv;
			fw_s4 <= fw;
			fv_s5 <= fv_s4;
			fw_s5 <= fw_s4;
			fw_s6 <= fw_s5;
		end
	end

	// x lerps, stages 5-6
	logic signed [VW-1:0] lx [4];
	logic [FB:0] fu_s4;
	always_ff @(posedge clk) begin
		if (en) fu_s4 <= fu;
	end
	for (genvar j = 0; j < 4; j++) begin : g_lx
		gn3_lerp #(.FRAC_BITS(FB), .VW(VW)) u_l (.clk, .en, .t(fu_s4),
			.a(g_s4[2*j]), .b(g_s4[2*j+1]), .y(lx[j]));
	end

	// register x results; y lerps take them with fade v at stage 7
	logic [FB:0] fv_s6, fv_s7;
	logic signed [VW-1:0] lx_s7 [4];
	always_ff @(posedge clk) begin
		if (en) begin
			fv_s6 <= fv_s5;
			fv_s7 <= fv_s6;
			lx_s7 <= lx;
		end
	end
	logic signed [VW-1:0] ly [2];
	for (genvar j = 0; j < 2; j++) begin : g_ly
		gn3_lerp #(.FRAC_BITS(FB), .VW(VW)) u_l (.clk, .en, .t(fv_s7),
			.a(lx_s7[2*j]), .b(lx_s7[2*j+1]), .y(ly[j]));
	end

	// z lerp, fed at stage 10
	logic [FB:0] fw_s7, fw_s8, fw_s9, fw_s10;
	logic signed [VW-1:0] ly_s10 [2];
	always_ff @(posedge clk) begin
		if (en) begin
			fw_s7  <= fw_s6;
			fw_s8  <= fw_s7;
			fw_s9  <= fw_s8;
			fw_s10 <= fw_s9;
			ly_s10 <= ly;
		end
	end
	logic signed [VW-1:0] res;
	gn3_lerp #(.FRAC_BITS(FB), .VW(VW)) u_lz (.clk, .en, .t(fw_s10),
		.a(ly_s10[0]), .b(ly_s10[1]), .y(res));

	// map to 0..1 and saturate
	logic signed [VW:0] val;
	logic [SW-1:0] val_u, sc;
	logic [OutW-1:0] out_s13;
	assign val = (VW+1)'(res) + (VW+1)'(SV);
	assign val_u = SW'($unsigned(val));
	always_comb begin
		if (FB >= 15) sc = val_u >> (FB >= 15 ? FB-15 : 0);
		else sc = val_u << (FB < 15 ? 15-FB : 0);
	end
	always_ff @(posedge clk) begin
		if (en) begin
			if (val <= 0) out_s13 <= '0;
			else if (sc > SW'(65536)) out_s13 <= OutW'(65536);
			else out_s13 <= OutW'(sc);
		end
	end
	assign m_axis_tdata = {7'd0, out_s13};

endmodule
`default_nettype wire

// ----- tb/sv/gn3_checker.sv -----
`default_nettype none
module gn3_checker
	import gn3_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [71:0] s_axis_tdata,  // coord_x, coord_y, coord_z
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [23:0] m_axis_tdata,  // noise_value, zero fill
	output int               fail_count,
	output int               pending_count
);

	localparam longint Scale = longint'(1) << FRAC_BITS;

	logic [16:0] noise_queue[$];

	function automatic longint floor_div_s(input longint v);
		if (v >= 0)
			return v >>> FRAC_BITS;
		return -((-v + Scale - 1) >>> FRAC_BITS);
	endfunction

	function automatic longint fade_of(input longint f);
		longint q, c, r;
		q = 10 * Scale - ((f * (15 * Scale - 6 * f)) >>> FRAC_BITS);
		c = (((f * f) >>> FRAC_BITS) * f) >>> FRAC_BITS;
		r = (c * q) >>> FRAC_BITS;
		if (r > Scale)
			r = Scale;
		return r;
	endfunction

	function automatic longint mix(input longint t, input longint a, input longint b);
		return a + floor_div_s(t * (b - a));
	endfunction

	function automatic longint grad_dot(input logic [7:0] hv, input longint x,
			input longint y, input longint z);
		logic [3:0] h;
		longint u, v;
		h = hv[3:0];
		u = (h < 8) ? x : y;
		v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
		return (h[0] ? -u : u) + (h[1] ? -v : v);
	endfunction

	function automatic logic [7:0] hash_at(input int i);
		return PERM[i & 255];
	endfunction

	function automatic logic [16:0] noise_of(input logic [71:0] d);
		logic [23:0] c[3];
		int ci[3], a, b, aa, ab, ba, bb;
		longint f[3], fd[3], x1, y1, z1, l0, l1, res, val, o;
		for (int k = 0; k < 3; k++) begin
			c[k] = d[24*k +: 24];
			ci[k] = int'((c[k] >> FRAC_BITS) & 24'hFF);
			f[k] = longint'(c[k] & ((24'd1 << FRAC_BITS) - 1));
			fd[k] = fade_of(f[k]);
		end
		a = hash_at(ci[0]) + ci[1];
		aa = hash_at(a) + ci[2];
		ab = hash_at(a + 1) + ci[2];
		b = hash_at(ci[0] + 1) + ci[1];
		ba = hash_at(b) + ci[2];
		bb = hash_at(b + 1) + ci[2];
		x1 = f[0] - Scale;
		y1 = f[1] - Scale;
		z1 = f[2] - Scale;
		l0 = mix(fd[1],
			mix(fd[0], grad_dot(hash_at(aa), f[0], f[1], f[2]),
				grad_dot(hash_at(ba), x1, f[1], f[2])),
			mix(fd[0], grad_dot(hash_at(ab), f[0], y1, f[2]),
				grad_dot(hash_at(bb), x1, y1, f[2])));
		l1 = mix(fd[1],
			mix(fd[0], grad_dot(hash_at(aa + 1), f[0], f[1], z1),
				grad_dot(hash_at(ba + 1), x1, f[1], z1)),
			mix(fd[0], grad_dot(hash_at(ab + 1), f[0], y1, z1),
				grad_dot(hash_at(bb + 1), x1, y1, z1)));
		res = mix(fd[2], l0, l1);
		val = res + Scale;
		if (val <= 0)
			o = 0;
		else if (FRAC_BITS >= 15)
			o = val >>> (FRAC_BITS - 15);
		else
			o = val <<< (15 - FRAC_BITS);
		if (o > 65536)
			o = 65536;
		return o[16:0];
	endfunction

	assign pending_count = noise_queue.size();

	// Predict on each input transfer, compare on each output transfer
	always @(posedge clk or negedge arst_n) begin
		logic [16:0] want;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				noise_queue.push_back(noise_of(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				if (noise_queue.size() == 0) begin
					$error("noise_value: unexpected transfer, actual %0d", m_axis_tdata[16:0]);
					fail_count <= fail_count + 1;
				end else begin
					want = noise_queue.pop_front();
					if (m_axis_tdata[16:0] !== want) begin
						$error("noise_value: expected %0d actual %0d", want, m_axis_tdata[16:0]);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

// ----- tb/sv/tb_gradient_noise_3d.sv -----
`default_nettype none
module tb_gradient_noise_3d;
	localparam int Latency = 13;
	localparam int WatchLimit = 5000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata = '0;  // coord_x, coord_y, coord_z
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;       // noise_value, zero fill
	int          fail_count, pending_count;
	int          idle_cycles = 0;
	bit          stim_done = 1'b0;
	bit          hold_off = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	gradient_noise_3d uut (.*);

	gn3_checker chk (.*);

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 40);
		if ($urandom_range(0, 2) == 0)
			return $urandom_range(1, 3);
		return 0;
	endfunction

	function automatic logic [23:0] rand_coord();
		logic [23:0] c;
		c = 24'($urandom());
		case ($urandom_range(0, 5))
			0: c[15:0] = 16'h0000;
			1: c[15:0] = 16'hFFFF;
			2: c[15:0] = 16'h8000;
			default: ;
		endcase
		return c;
	endfunction

	task automatic send_point(input logic [23:0] x, input logic [23:0] y, input logic [23:0] z);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {z, y, x};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Receiver: random stalls, one long hold-off when asked
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				m_axis_tready <= 1'b0;
				repeat (200) @(posedge clk);
				hold_off = 1'b0;
			end
			g = gap_len();
			if (g > 0) begin
				m_axis_tready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		logic [23:0] edge_vals[6];
		edge_vals = '{24'h000000, 24'hFFFFFF, 24'h00FFFF, 24'hFF0000, 24'h7F8000, 24'h010001};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Directed corners, wrap of the cell index, zero and full fractions
		for (int i = 0; i < 6; i++)
			send_point(edge_vals[i], edge_vals[(i + 1) % 6], edge_vals[(i + 3) % 6]);
		for (int i = 0; i < 6; i++)
			send_point(edge_vals[i], edge_vals[i], edge_vals[i]);
		send_point(24'hFF4000, 24'h00C000, 24'hFFFFFF);
		send_point(24'h123456, 24'hABCDEF, 24'h555555);
		// Random points; fill the pipeline during one long receiver stall
		for (int n = 0; n < 1100; n++) begin
			if (n == 300)
				hold_off = 1'b1;
			send_point(rand_coord(), rand_coord(), rand_coord());
		end
		s_axis_tvalid <= 1'b0;
		stim_done = 1'b1;
		while (pending_count != 0)
			@(posedge clk);
		repeat (Latency * 3) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
`default_nettype wire
